### rtl/irpw_pkg.sv
// Shared types, constants and helpers for the IR pulse width symbol decoder.
package irpw_pkg;

   localparam int CHANNEL_MAX = 8;
   localparam int BITS_W      = 7;
   localparam int WORD_W      = 16;
   localparam int CNT_W       = 8;
   localparam int CSR_IDX_W   = 3;
   localparam int CSR_DATA_W  = 8;

   localparam logic [CNT_W-1:0] CNT_MAX = 8'hFF;

   typedef enum logic [1:0] {
      PH_IDLE     = 2'd0,
      PH_COUNT    = 2'd1,
      PH_CLASSIFY = 2'd2
   } phase_type;

   typedef enum logic [1:0] {
      CODE_NONE  = 2'd0,
      CODE_ZERO  = 2'd1,
      CODE_ONE   = 2'd2,
      CODE_START = 2'd3
   } code_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      REG_ONE_MIN      = 3'd0,
      REG_ONE_MARGIN   = 3'd1,
      REG_ZERO_MIN     = 3'd2,
      REG_ZERO_MARGIN  = 3'd3,
      REG_START_MIN    = 3'd4,
      REG_START_MARGIN = 3'd5
   } reg_idx_type;

   typedef struct packed {
      logic [CNT_W-1:0] one_min;
      logic [CNT_W-1:0] one_margin;
      logic [CNT_W-1:0] zero_min;
      logic [CNT_W-1:0] zero_margin;
      logic [CNT_W-1:0] start_min;
      logic [CNT_W-1:0] start_margin;
   } cfg_type;

   // merge control from the request side
   typedef struct packed {
      logic sample;
      logic transfer;
   } req_ctl_type;

   // upper bound formed at 9 bits so lo + margin never wraps
   function automatic logic in_window(input logic [CNT_W-1:0] c,
                                      input logic [CNT_W-1:0] lo,
                                      input logic [CNT_W-1:0] margin);
      logic [CNT_W:0] hi;
      hi = {1'b0, lo} + {1'b0, margin};
      return (c >= lo) && ({1'b0, c} <= hi);
   endfunction

endpackage

### rtl/ir_pulse_width_symbol_decoder_top.sv
// Top level: config registers, channel lanes and symbol word merge.
// Throughput: one request per cycle while req_stall is low; every channel lane advances in the same cycle.
// Sample requests give no response; a transfer's response is valid the cycle after it.
// A request stalls only while the response register is full and rsp_stall is high.
// Synchronous reset: lanes idle, symbol word cleared, thresholds to their defaults.
// Pulse counters are not reset; they are loaded before any read.
module ir_pulse_width_symbol_decoder_top
   import irpw_pkg::*;
#(
   parameter int CHANNELS = 7
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_func,
   input  logic [6:0]            req_channel_bits,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [5:0]            rsp_symbols_high,
   output logic [7:0]            rsp_symbols_low,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   cfg_type     cfg_ff, cfg_in;
   req_ctl_type ctl;
   logic        req_acc;
   code_type    lane_code [CHANNELS];

   assign req_stall    = rsp_valid & rsp_stall;
   assign req_acc      = req_valid & ~req_stall;
   assign ctl.sample   = req_acc & ~req_func;
   assign ctl.transfer = req_acc & req_func;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            REG_ONE_MIN:      cfg_in.one_min      = csr_wdata;
            REG_ONE_MARGIN:   cfg_in.one_margin   = csr_wdata;
            REG_ZERO_MIN:     cfg_in.zero_min     = csr_wdata;
            REG_ZERO_MARGIN:  cfg_in.zero_margin  = csr_wdata;
            REG_START_MIN:    cfg_in.start_min    = csr_wdata;
            REG_START_MARGIN: cfg_in.start_margin = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.one_min      <= 8'd16;
         cfg_ff.one_margin   <= 8'd3;
         cfg_ff.zero_min     <= 8'd8;
         cfg_ff.zero_margin  <= 8'd3;
         cfg_ff.start_min    <= 8'd32;
         cfg_ff.start_margin <= 8'd7;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   for (genvar i = 0; i < CHANNELS; i++) begin : g_lane
      logic lane_bit;
      // a channel past the input field sees a constant low
      if (i < BITS_W) begin : g_bit
         assign lane_bit = req_channel_bits[i];
      end else begin : g_nobit
         assign lane_bit = 1'b0;
      end

      irpw_lane u_lane (
         .clock     (clock),
         .reset     (reset),
         .sample_en (ctl.sample),
         .bit_in    (lane_bit),
         .cfg       (cfg_ff),
         .code      (lane_code[i])
      );
   end

   irpw_merge #(
      .CHANNELS (CHANNELS)
   ) u_merge (
      .clock            (clock),
      .reset            (reset),
      .ctl              (ctl),
      .lane_code        (lane_code),
      .rsp_stall        (rsp_stall),
      .rsp_valid        (rsp_valid),
      .rsp_symbols_high (rsp_symbols_high),
      .rsp_symbols_low  (rsp_symbols_low)
   );

   a_xfer_rsp: assert property (@(posedge clock) disable iff (reset)
      ctl.transfer |=> rsp_valid)
      else $error("transfer request gave no response");

   a_xfer_clears: assert property (@(posedge clock) disable iff (reset)
      ctl.transfer ##1 ctl.transfer |=> (rsp_symbols_low == 8'd0 && rsp_symbols_high == 6'd0))
      else $error("symbol word not cleared by transfer");

   a_stall_full: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> rsp_valid)
      else $error("request stalled with empty response register");

   a_csr_write: assert property (@(posedge clock) disable iff (reset)
      (csr_we && csr_index == REG_ONE_MIN) |=> cfg_ff.one_min == $past(csr_wdata))
      else $error("one_min write lost");

endmodule

### rtl/irpw_lane.sv
// One channel: pulse counter, phase machine and window classifier.
module irpw_lane
   import irpw_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    sample_en,
   input  logic    bit_in,
   input  cfg_type cfg,
   output code_type code
);

   phase_type        phase_ff, phase_in;
   logic [CNT_W-1:0] count_ff, count_in;
   code_type         class_code;

   always_comb begin
      if (in_window(count_ff, cfg.one_min, cfg.one_margin))
         class_code = CODE_ONE;
      else if (in_window(count_ff, cfg.zero_min, cfg.zero_margin))
         class_code = CODE_ZERO;
      else if (in_window(count_ff, cfg.start_min, cfg.start_margin))
         class_code = CODE_START;
      else
         class_code = CODE_NONE;
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      code     = CODE_NONE;
      if (sample_en) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (bit_in) begin
                  count_in = CNT_W'(1);
                  phase_in = PH_COUNT;
               end
            end
            PH_COUNT: begin
               if (bit_in) begin
                  if (count_ff != CNT_MAX)
                     count_in = count_ff + CNT_W'(1);
               end else begin
                  phase_in = PH_CLASSIFY;
               end
            end
            PH_CLASSIFY: begin
               // this sample's bit is ignored
               code     = class_code;
               phase_in = PH_IDLE;
            end
            default: phase_in = PH_IDLE;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset)
         phase_ff <= PH_IDLE;
      else
         phase_ff <= phase_in;
   end

   always_ff @(posedge clock) begin
      count_ff <= count_in;
   end

endmodule

### rtl/irpw_merge.sv
// Merges lane codes into the packed symbol word and holds the response register.
module irpw_merge
   import irpw_pkg::*;
#(
   parameter int CHANNELS = 7
) (
   input  logic        clock,
   input  logic        reset,
   input  req_ctl_type ctl,
   input  code_type    lane_code [CHANNELS],
   input  logic        rsp_stall,
   output logic        rsp_valid,
   output logic [5:0]  rsp_symbols_high,
   output logic [7:0]  rsp_symbols_low
);

   logic [WORD_W-1:0] word_ff, word_in;
   logic [WORD_W-1:0] sample_word;
   logic              valid_ff, valid_in;
   logic [5:0]        high_ff, high_in;
   logic [7:0]        low_ff, low_in;

   always_comb begin
      sample_word = '0;
      for (int i = 0; i < CHANNELS; i++)
         sample_word[2*i +: 2] = lane_code[i];
   end

   always_comb begin
      word_in  = word_ff;
      valid_in = valid_ff & rsp_stall;
      high_in  = high_ff;
      low_in   = low_ff;
      if (ctl.transfer) begin
         valid_in = 1'b1;
         high_in  = word_ff[13:8];
         low_in   = word_ff[7:0];
         word_in  = '0;
      end else if (ctl.sample) begin
         word_in = word_ff | sample_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         word_ff  <= '0;
         valid_ff <= 1'b0;
      end else begin
         word_ff  <= word_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      high_ff <= high_in;
      low_ff  <= low_in;
   end

   assign rsp_valid        = valid_ff;
   assign rsp_symbols_high = high_ff;
   assign rsp_symbols_low  = low_ff;

endmodule
